@@ design/smm_pkg.sv @@
package smm_pkg;

    localparam int ARRAY_SIZE = 4;
    localparam int CELLS      = ARRAY_SIZE * ARRAY_SIZE;
    localparam int STEPS      = 3 * ARRAY_SIZE - 2;
    localparam int IDX_W      = $clog2(ARRAY_SIZE);
    localparam int FEED_LEN   = 2 * ARRAY_SIZE - 1;
    localparam int RUN_CNT_W  = $clog2(STEPS + 1);
    localparam int DATA_W     = 16;
    localparam int SUM_W      = 32;

    typedef enum logic [1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_START  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             start;
        logic             step;
        logic             acc;
        logic             emit;
        logic             emit_last;
        logic [IDX_W-1:0] emit_row;
        logic [IDX_W-1:0] emit_col;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

@@ design/smm_ctrl.sv @@
module smm_ctrl
    import smm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_opcode,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(ARRAY_SIZE - 1);
    localparam logic [RUN_CNT_W-1:0] LAST_STEP = RUN_CNT_W'(STEPS);

    state_t               state_reg, state_next;
    logic [RUN_CNT_W-1:0] run_cnt_reg, run_cnt_next;
    logic [IDX_W-1:0]     drow_reg, drow_next;
    logic [IDX_W-1:0]     dcol_reg, dcol_next;
    logic                 accept;
    logic                 drain_end;

    assign accept    = s_valid && (state_reg == ST_IDLE);
    assign drain_end = (drow_reg == LAST_IDX) && (dcol_reg == LAST_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            run_cnt_reg <= '0;
            drow_reg    <= '0;
            dcol_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            run_cnt_reg <= run_cnt_next;
            drow_reg    <= drow_next;
            dcol_reg    <= dcol_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_opcode == OP_START)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (run_cnt_reg == LAST_STEP) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.out_free && drain_end) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The run counter covers every mesh step and a last pass that adds
    // the last registered products.
    always_comb begin
        run_cnt_next = run_cnt_reg;
        drow_next    = drow_reg;
        dcol_next    = dcol_reg;
        case (state_reg)
            ST_IDLE: begin
                run_cnt_next = '0;
            end
            ST_RUN: begin
                run_cnt_next = run_cnt_reg + 1'b1;
                drow_next    = '0;
                dcol_next    = '0;
            end
            ST_DRAIN: begin
                if (status.out_free) begin
                    if (dcol_reg == LAST_IDX) begin
                        dcol_next = '0;
                        drow_next = drow_reg + 1'b1;
                    end else begin
                        dcol_next = dcol_reg + 1'b1;
                    end
                end
            end
            default: run_cnt_next = '0;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        cmd           = '0;
        cmd.emit_row  = drow_reg;
        cmd.emit_col  = dcol_reg;
        cmd.emit_last = drain_end;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (opcode_t'(s_opcode))
                        OP_LOAD_A: cmd.wr_a  = 1'b1;
                        OP_LOAD_B: cmd.wr_b  = 1'b1;
                        OP_START:  cmd.start = 1'b1;
                        default:   cmd.wr_a  = 1'b0;
                    endcase
                end
            end
            ST_RUN: begin
                cmd.step = (run_cnt_reg < LAST_STEP);
                cmd.acc  = 1'b1;
            end
            ST_DRAIN: begin
                cmd.emit = status.out_free;
            end
            default: cmd.wr_a = 1'b0;
        endcase
    end

endmodule

@@ design/smm_datapath.sv @@
module smm_datapath
    import smm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic [1:0]               s_row,
    input  logic [1:0]               s_col,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_out_row,
    output logic [1:0]               m_out_col,
    output logic signed [SUM_W-1:0]  m_sum,
    output logic                     m_last
);

    logic signed [DATA_W-1:0] a_store_reg [ARRAY_SIZE][ARRAY_SIZE];
    logic signed [DATA_W-1:0] b_store_reg [ARRAY_SIZE][ARRAY_SIZE];
    logic signed [DATA_W-1:0] feed_a_reg  [ARRAY_SIZE][FEED_LEN];
    logic signed [DATA_W-1:0] feed_b_reg  [ARRAY_SIZE][FEED_LEN];
    logic signed [DATA_W-1:0] pe_a_reg    [ARRAY_SIZE][ARRAY_SIZE];
    logic signed [DATA_W-1:0] pe_b_reg    [ARRAY_SIZE][ARRAY_SIZE];
    logic signed [SUM_W-1:0]  prod_reg    [ARRAY_SIZE][ARRAY_SIZE];
    logic signed [SUM_W-1:0]  sum_reg     [ARRAY_SIZE][ARRAY_SIZE];

    logic                     m_valid_reg;
    logic [1:0]               out_row_reg;
    logic [1:0]               out_col_reg;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic                     out_last_reg;
    logic                     wr_in_range;
    logic [IDX_W-1:0]         wr_row;
    logic [IDX_W-1:0]         wr_col;

    assign wr_in_range = (int'(s_row) < ARRAY_SIZE) && (int'(s_col) < ARRAY_SIZE);
    assign wr_row      = IDX_W'(s_row);
    assign wr_col      = IDX_W'(s_col);

    // The element stores reset to zero, so a start with no prior writes
    // multiplies zero matrices.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ARRAY_SIZE; r++) begin
                for (int c = 0; c < ARRAY_SIZE; c++) begin
                    a_store_reg[r][c] <= '0;
                    b_store_reg[r][c] <= '0;
                end
            end
        end else if (wr_in_range) begin
            if (cmd.wr_a) begin
                a_store_reg[wr_row][wr_col] <= s_value;
            end
            if (cmd.wr_b) begin
                b_store_reg[wr_row][wr_col] <= s_value;
            end
        end
    end

    // Each feed line is loaded with its row of A (or column of B) already
    // skewed by leading zeros, then shifted one place per mesh step.
    for (genvar i = 0; i < ARRAY_SIZE; i++) begin : gen_feed
        for (genvar p = 0; p < FEED_LEN; p++) begin : gen_tap
            logic signed [DATA_W-1:0] load_a;
            logic signed [DATA_W-1:0] load_b;
            logic signed [DATA_W-1:0] shift_a;
            logic signed [DATA_W-1:0] shift_b;

            if ((p >= i) && (p < i + ARRAY_SIZE)) begin : gen_load
                assign load_a = a_store_reg[i][p-i];
                assign load_b = b_store_reg[p-i][i];
            end else begin : gen_zero
                assign load_a = '0;
                assign load_b = '0;
            end

            if (p == FEED_LEN - 1) begin : gen_tail
                assign shift_a = '0;
                assign shift_b = '0;
            end else begin : gen_next
                assign shift_a = feed_a_reg[i][p+1];
                assign shift_b = feed_b_reg[i][p+1];
            end

            always_ff @(posedge aclk) begin
                if (cmd.start) begin
                    feed_a_reg[i][p] <= load_a;
                    feed_b_reg[i][p] <= load_b;
                end else if (cmd.step) begin
                    feed_a_reg[i][p] <= shift_a;
                    feed_b_reg[i][p] <= shift_b;
                end
            end
        end
    end

    // Processing elements: the product is registered and added to the
    // partial sum in the following cycle.
    for (genvar i = 0; i < ARRAY_SIZE; i++) begin : gen_pe_row
        for (genvar j = 0; j < ARRAY_SIZE; j++) begin : gen_pe_col
            logic signed [DATA_W-1:0] a_in;
            logic signed [DATA_W-1:0] b_in;
            logic signed [SUM_W-1:0]  prod_next;

            if (j == 0) begin : gen_a_edge
                assign a_in = feed_a_reg[i][0];
            end else begin : gen_a_mesh
                assign a_in = pe_a_reg[i][j-1];
            end

            if (i == 0) begin : gen_b_edge
                assign b_in = feed_b_reg[j][0];
            end else begin : gen_b_mesh
                assign b_in = pe_b_reg[i-1][j];
            end

            assign prod_next = a_in * b_in;

            always_ff @(posedge aclk) begin
                if (cmd.start) begin
                    pe_a_reg[i][j] <= '0;
                    pe_b_reg[i][j] <= '0;
                    prod_reg[i][j] <= '0;
                    sum_reg[i][j]  <= '0;
                end else begin
                    if (cmd.step) begin
                        pe_a_reg[i][j] <= a_in;
                        pe_b_reg[i][j] <= b_in;
                        prod_reg[i][j] <= prod_next;
                    end else begin
                        prod_reg[i][j] <= '0;
                    end
                    if (cmd.acc) begin
                        sum_reg[i][j] <= sum_reg[i][j] + prod_reg[i][j];
                    end
                end
            end
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_row_reg  <= 2'(cmd.emit_row);
            out_col_reg  <= 2'(cmd.emit_col);
            out_sum_reg  <= sum_reg[cmd.emit_row][cmd.emit_col];
            out_last_reg <= cmd.emit_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_out_row = out_row_reg;
    assign m_out_col = out_col_reg;
    assign m_sum     = out_sum_reg;
    assign m_last    = out_last_reg;

endmodule

@@ design/systolic_matrix_multiply.sv @@
// Load transfers (A or B element writes) are taken one per cycle while the block is idle
// and give no result. A start transfer runs the mesh through 3N-2 steps plus a final
// pass that adds the last registered products.
// The N*N results then leave one per cycle while m_ready is high; the next
// transfer is taken once the last result has entered the output register.
// aresetn (synchronous, active low) clears the control, the output valid and both stores.
module systolic_matrix_multiply
    import smm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_opcode,
    input  logic [1:0]               s_row,
    input  logic [1:0]               s_col,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_out_row,
    output logic [1:0]               m_out_col,
    output logic signed [SUM_W-1:0]  m_sum,
    output logic                     m_last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    smm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    smm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_row     (s_row),
        .s_col     (s_col),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_row (m_out_row),
        .m_out_col (m_out_col),
        .m_sum     (m_sum),
        .m_last    (m_last)
    );

endmodule

@@ design/smm_checker.sv @@
module smm_checker
    import smm_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic [1:0]               s_opcode,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [1:0]               m_out_row,
    input logic [1:0]               m_out_col,
    input logic signed [SUM_W-1:0]  m_sum,
    input logic                     m_last
);

    // A stalled result holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sum) && $stable(m_last)))
        else $error("stalled result changed");

    // Reset leaves the block ready for input and with no result pending.
    assert property (@(posedge aclk) !aresetn |=> (s_ready && !m_valid))
        else $error("state after reset wrong");

    // A start transfer closes the input channel while the mesh runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_opcode == OP_START)) |=> !s_ready)
        else $error("input still open after start");

    // The flagged result is the bottom-right element.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |->
            ((m_out_row == 2'(ARRAY_SIZE - 1)) && (m_out_col == 2'(ARRAY_SIZE - 1))))
        else $error("last flag on wrong element");

    // While a result other than the last is on offer, the input stays closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> !s_ready)
        else $error("input open before the last result");

endmodule

bind systolic_matrix_multiply smm_checker u_smm_checker (.*);

@@ test/systolic_matrix_multiply_tb.sv @@
module systolic_matrix_multiply_tb;
    import smm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         LOAD_ITEMS   = 210;
    localparam int         SETTLE_TICKS = 3 * ARRAY_SIZE + 8;

    typedef struct {
        logic [1:0]       row;
        logic [1:0]       col;
        logic [SUM_W-1:0] sum;
        logic             last;
    } product_t;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_SLUGGISH,
        RX_PATTERN
    } rx_mode_t;

    class matmul_scoreboard;
        logic signed [DATA_W-1:0] a_elem [ARRAY_SIZE][ARRAY_SIZE];
        logic signed [DATA_W-1:0] b_elem [ARRAY_SIZE][ARRAY_SIZE];
        product_t                 product_q [$];
        int                       errors;

        function new();
            errors = 0;
            for (int i = 0; i < ARRAY_SIZE; i++) begin
                for (int j = 0; j < ARRAY_SIZE; j++) begin
                    a_elem[i][j] = '0;
                    b_elem[i][j] = '0;
                end
            end
        endfunction

        function int pending();
            return product_q.size();
        endfunction

        // Every product lands inside the 3N-2 step window, so each sum is
        // the plain dot product of a row of A and a column of B.
        function void predict_products();
            logic [SUM_W-1:0]        acc;
            logic signed [SUM_W-1:0] term;
            product_t                p;
            for (int i = 0; i < ARRAY_SIZE; i++) begin
                for (int j = 0; j < ARRAY_SIZE; j++) begin
                    acc = '0;
                    for (int k = 0; k < ARRAY_SIZE; k++) begin
                        term = a_elem[i][k] * b_elem[k][j];
                        acc  = acc + term;
                    end
                    p.row  = 2'(i);
                    p.col  = 2'(j);
                    p.sum  = acc;
                    p.last = (i == ARRAY_SIZE - 1) && (j == ARRAY_SIZE - 1);
                    product_q.push_back(p);
                end
            end
        endfunction

        function void note_input(logic [1:0] op, logic [1:0] row, logic [1:0] col,
                                 logic signed [DATA_W-1:0] value);
            case (op)
                OP_LOAD_A: begin
                    if (row < ARRAY_SIZE && col < ARRAY_SIZE)
                        a_elem[row][col] = value;
                end
                OP_LOAD_B: begin
                    if (row < ARRAY_SIZE && col < ARRAY_SIZE)
                        b_elem[row][col] = value;
                end
                OP_START: predict_products();
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [1:0] row, logic [1:0] col, logic [SUM_W-1:0] sum,
                          logic last);
            product_t want;
            if (product_q.size() == 0) begin
                report($sformatf("result with nothing expected: row %0d col %0d sum %0d",
                                 row, col, $signed(sum)));
                return;
            end
            want = product_q.pop_front();
            if (row !== want.row)
                report($sformatf("out_row %0d, expected %0d", row, want.row));
            if (col !== want.col)
                report($sformatf("out_col %0d, expected %0d", col, want.col));
            if (sum !== want.sum)
                report($sformatf("sum %0d at (%0d,%0d), expected %0d", $signed(sum),
                                 want.row, want.col, $signed(want.sum)));
            if (last !== want.last)
                report($sformatf("last %0b at (%0d,%0d), expected %0b", last,
                                 want.row, want.col, want.last));
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_opcode;
    logic [1:0]               s_row;
    logic [1:0]               s_col;
    logic signed [DATA_W-1:0] s_value;
    logic                     m_valid;
    logic                     m_ready;
    logic [1:0]               m_out_row;
    logic [1:0]               m_out_col;
    logic signed [SUM_W-1:0]  m_sum;
    logic                     m_last;

    matmul_scoreboard sb = new();
    int               burst_left;
    int               loads_sent;

    systolic_matrix_multiply DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_row     (s_row),
        .s_col     (s_col),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_row (m_out_row),
        .m_out_col (m_out_col),
        .m_sum     (m_sum),
        .m_last    (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL systolic_matrix_multiply");
        $finish;
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Called and returns at a falling edge, after the transfer and any burst gap.
    task automatic send_item(logic [1:0] op, logic [1:0] row, logic [1:0] col,
                             logic [DATA_W-1:0] value);
        s_valid  = 1'b1;
        s_opcode = op;
        s_row    = row;
        s_col    = col;
        s_value  = value;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_input(op, row, col, value);
        if (op != OP_UNUSED)
            loads_sent++;
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (sb.pending() > 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_random_load();
        if ($urandom_range(0, 11) == 0)
            send_item(OP_UNUSED, 2'($urandom), 2'($urandom), 16'($urandom));
        send_item($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A, 2'($urandom),
                  2'($urandom), pick_value());
    endtask

    // Result channel: m_ready follows one of four stall modes, picked anew at random.
    initial begin
        rx_mode_t mode;
        int       left;
        int       tick;
        mode    = RX_STEADY;
        left    = 0;
        tick    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = $urandom_range(8, 80);
            end
            left--;
            tick++;
            case (mode)
                RX_STEADY:   m_ready = 1'b1;
                RX_COIN:     m_ready = $urandom_range(0, 1);
                RX_SLUGGISH: m_ready = ($urandom_range(0, 7) == 0);
                default:     m_ready = (tick % 5 != 0) && (tick % 7 != 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_out_row, m_out_col, m_sum, m_last);
    end

    initial begin
        s_valid    = 1'b0;
        s_opcode   = OP_LOAD_A;
        s_row      = '0;
        s_col      = '0;
        s_value    = '0;
        aresetn    = 1'b0;
        burst_left = 4;
        loads_sent = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Start on the reset contents, then an unused opcode that must be ignored.
        send_item(OP_START, 2'd0, 2'd0, 16'h0000);
        send_item(OP_UNUSED, 2'd3, 2'd3, 16'hFFFF);
        // Row 0 of A and column 0 of B at the most negative value: the sum wraps.
        for (int k = 0; k < ARRAY_SIZE; k++) begin
            send_item(OP_LOAD_A, 2'd0, 2'(k), 16'h8000);
            send_item(OP_LOAD_B, 2'(k), 2'd0, 16'h8000);
        end
        send_item(OP_START, 2'd3, 2'd2, 16'h5A5A);
        send_item(OP_LOAD_A, 2'd3, 2'd3, 16'h7FFF);
        send_item(OP_LOAD_B, 2'd3, 2'd3, 16'h7FFF);
        send_item(OP_LOAD_A, 2'd3, 2'd2, 16'h8000);
        send_item(OP_LOAD_B, 2'd2, 2'd3, 16'h7FFF);
        send_item(OP_LOAD_A, 2'd1, 2'd2, 16'hFFFF);
        send_item(OP_LOAD_B, 2'd2, 2'd1, 16'h0001);
        // Field values on a start transfer are don't-care.
        send_item(OP_START, 2'd3, 2'd3, 16'hFFFF);
        wait_drained();

        while (loads_sent < LOAD_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                for (int i = 0; i < ARRAY_SIZE; i++) begin
                    for (int j = 0; j < ARRAY_SIZE; j++) begin
                        send_item(OP_LOAD_A, 2'(i), 2'(j), pick_value());
                        send_item(OP_LOAD_B, 2'(i), 2'(j), pick_value());
                    end
                end
            end else begin
                repeat ($urandom_range(0, 10)) send_random_load();
            end
            send_item(OP_START, 2'($urandom), 2'($urandom), 16'($urandom));
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS systolic_matrix_multiply");
        else
            $display("FAIL systolic_matrix_multiply");
        $finish;
    end

endmodule

@@ filelist.f @@
design/smm_pkg.sv
design/smm_ctrl.sv
design/smm_datapath.sv
design/systolic_matrix_multiply.sv
design/smm_checker.sv
test/systolic_matrix_multiply_tb.sv
